// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the Burning Ship escape-time unit.
// ----------------------------------------------------------------------------
package bse_pkg;

   // Pixel index bits that take part in the coordinate product
   localparam int INDEX_BITS = 12;
   // Width of the iteration counter
   localparam int COUNT_BITS = 16;

   // Fixed field widths of the stream payloads
   localparam int COLUMN_BITS    = 12;
   localparam int ROW_BITS       = 12;
   localparam int REQ_TDATA_BITS = 24;
   localparam int COUNT_OUT_BITS = 16;
   localparam int RSP_TDATA_BITS = 16;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_ORIGIN     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_STEP       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAG_ORIGIN     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAG_STEP       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT = 3'd4;

   // Register reset values
   localparam logic signed [31:0] REAL_ORIGIN_RESET = -32'sd536870912;
   localparam logic [30:0]        REAL_STEP_RESET   = 31'd1048576;
   localparam logic signed [31:0] IMAG_ORIGIN_RESET = -32'sd536870912;
   localparam logic [30:0]        IMAG_STEP_RESET   = 31'd1048576;
   localparam logic [15:0]        LIMIT_RESET       = 16'd255;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_idx;   // capture column and row
      logic coord_mul;  // form index * step products
      logic coord_add;  // add origins, saturate, clear z and count
      logic mul;        // form zr^2, zi^2 and zr*zi
      logic step;       // fold the new z and bump the count
      logic load_out;   // move count and inside flag to the result register
   } bse_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic limit_hit;  // count has reached the iteration limit
      logic escaped;    // zr^2 + zi^2 has reached 4.0
   } bse_status_type;

endpackage

// ===== rtl/bse_datapath.sv =====
// ----------------------------------------------------------------------------
// bse_datapath
// Configuration registers, coordinate generation, the square/product
// stage and the fold/count stage of the Burning Ship iteration.
// ----------------------------------------------------------------------------
module bse_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bse_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bse_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic [bse_pkg::COLUMN_BITS-1:0]       column,
   input  logic [bse_pkg::ROW_BITS-1:0]          row,
   input  bse_pkg::bse_cmd_type                  cmd,
   output bse_pkg::bse_status_type               status,
   output logic [bse_pkg::COUNT_OUT_BITS-1:0]    escape_count,
   output logic                                  inside_res
);
   import bse_pkg::*;

   localparam logic [15:0] IDX_MASK = 16'((32'd1 << INDEX_BITS) - 32'd1);
   localparam logic [31:0] CMAX32   = 32'((64'd1 << COUNT_BITS) - 64'd1);
   localparam logic [62:0] ESCAPE_Q56 = 63'd1 << 58;

   // Saturate origin + index*step to the signed 32-bit range
   function automatic logic signed [31:0] sat_coord(input logic signed [31:0] origin,
                                                   input logic [46:0] prod);
      logic signed [48:0] sum;
      sum = $signed({{17{origin[31]}}, origin}) + $signed({2'b00, prod});
      if (sum < -49'sd2147483648) begin
         return 32'sh80000000;
      end else if (sum > 49'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else begin
         return sum[31:0];
      end
   endfunction

   // Magnitude of a Q8.56 value, truncated to Q4.28 and saturated
   function automatic logic [30:0] fold(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [35:0] sh;
      mag = v[63] ? 64'(-v) : 64'(v);
      sh  = mag[63:28];
      if (sh > 36'h07FFFFFFF) begin
         return 31'h7FFFFFFF;
      end else begin
         return sh[30:0];
      end
   endfunction

   logic signed [31:0]     real_origin_ff, real_origin_in;
   logic [30:0]            real_step_ff, real_step_in;
   logic signed [31:0]     imag_origin_ff, imag_origin_in;
   logic [30:0]            imag_step_ff, imag_step_in;
   logic [15:0]            limit_ff, limit_in;

   logic [15:0]            col_ff, col_in;
   logic [15:0]            row_ff, row_in;
   logic [46:0]            rprod_ff, rprod_in;
   logic [46:0]            iprod_ff, iprod_in;
   logic signed [31:0]     cr_ff, cr_in;
   logic signed [31:0]     ci_ff, ci_in;
   logic [30:0]            zr_ff, zr_in;
   logic [30:0]            zi_ff, zi_in;
   logic [61:0]            rr_ff, rr_in;
   logic [61:0]            ii_ff, ii_in;
   logic [61:0]            pr_ff, pr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_OUT_BITS-1:0] out_count_ff, out_count_in;
   logic                   out_inside_ff, out_inside_in;

   logic [31:0]            lim32;
   logic [COUNT_BITS-1:0]  limit_cnt;
   logic [62:0]            sumsq;
   logic signed [63:0]     cr56;
   logic signed [63:0]     ci56;
   logic signed [63:0]     nr;
   logic signed [63:0]     ni;

   // Configuration writes
   always_comb begin
      real_origin_in = real_origin_ff;
      real_step_in   = real_step_ff;
      imag_origin_in = imag_origin_ff;
      imag_step_in   = imag_step_ff;
      limit_in       = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REAL_ORIGIN:     real_origin_in = $signed(csr_wdata);
            CSR_REAL_STEP:       real_step_in   = csr_wdata[30:0];
            CSR_IMAG_ORIGIN:     imag_origin_in = $signed(csr_wdata);
            CSR_IMAG_STEP:       imag_step_in   = csr_wdata[30:0];
            CSR_ITERATION_LIMIT: limit_in       = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Clamp the limit to the counter range
   assign lim32     = (32'(limit_ff) > CMAX32) ? CMAX32 : 32'(limit_ff);
   assign limit_cnt = lim32[COUNT_BITS-1:0];

   // Escape test and next z
   assign sumsq = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign cr56  = {{4{cr_ff[31]}}, cr_ff, 28'd0};
   assign ci56  = {{4{ci_ff[31]}}, ci_ff, 28'd0};
   assign nr    = $signed({2'b00, rr_ff}) - $signed({2'b00, ii_ff}) + cr56;
   assign ni    = $signed({1'b0, pr_ff, 1'b0}) + ci56;

   assign status.limit_hit = (count_ff >= limit_cnt);
   assign status.escaped   = (sumsq >= ESCAPE_Q56);

   // Datapath register updates
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      rprod_in      = rprod_ff;
      iprod_in      = iprod_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      rr_in         = rr_ff;
      ii_in         = ii_ff;
      pr_in         = pr_ff;
      count_in      = count_ff;
      out_count_in  = out_count_ff;
      out_inside_in = out_inside_ff;
      if (cmd.load_idx) begin
         col_in = 16'(column) & IDX_MASK;
         row_in = 16'(row) & IDX_MASK;
      end
      if (cmd.coord_mul) begin
         rprod_in = 47'(col_ff) * 47'(real_step_ff);
         iprod_in = 47'(row_ff) * 47'(imag_step_ff);
      end
      if (cmd.coord_add) begin
         cr_in    = sat_coord(real_origin_ff, rprod_ff);
         ci_in    = sat_coord(imag_origin_ff, iprod_ff);
         zr_in    = '0;
         zi_in    = '0;
         count_in = '0;
      end
      if (cmd.mul) begin
         rr_in = 62'(zr_ff) * 62'(zr_ff);
         ii_in = 62'(zi_ff) * 62'(zi_ff);
         pr_in = 62'(zr_ff) * 62'(zi_ff);
      end
      if (cmd.step) begin
         zr_in    = fold(nr);
         zi_in    = fold(ni);
         count_in = count_ff + 1'b1;
      end
      if (cmd.load_out) begin
         out_count_in  = COUNT_OUT_BITS'(count_ff);
         out_inside_in = (count_ff == limit_cnt);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= REAL_ORIGIN_RESET;
         real_step_ff   <= REAL_STEP_RESET;
         imag_origin_ff <= IMAG_ORIGIN_RESET;
         imag_step_ff   <= IMAG_STEP_RESET;
         limit_ff       <= LIMIT_RESET;
      end else begin
         real_origin_ff <= real_origin_in;
         real_step_ff   <= real_step_in;
         imag_origin_ff <= imag_origin_in;
         imag_step_ff   <= imag_step_in;
         limit_ff       <= limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      rprod_ff      <= rprod_in;
      iprod_ff      <= iprod_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      pr_ff         <= pr_in;
      count_ff      <= count_in;
      out_count_ff  <= out_count_in;
      out_inside_ff <= out_inside_in;
   end

   assign escape_count = out_count_ff;
   assign inside_res   = out_inside_ff;

endmodule

// ===== rtl/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for one pixel: coordinate setup, alternating multiply and fold
// phases, and hand-off to the result register.
// ----------------------------------------------------------------------------
module bse_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  bse_pkg::bse_status_type   status,
   output bse_pkg::bse_cmd_type      cmd
);
   import bse_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_COORD  = 6'b000010,
      ST_SETUP  = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_ADD    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_idx = 1'b1;
               state_in     = ST_COORD;
            end
         end
         ST_COORD: begin
            cmd.coord_mul = 1'b1;
            state_in      = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.coord_add = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            if (status.limit_hit) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (status.escaped) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a result that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while occupied");

   // An accepted item starts the coordinate setup
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_COORD))
      else $error("accepted item did not start setup");

   // No map step once the count has reached the limit
   a_no_step_past_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> !status.limit_hit)
      else $error("map step issued at the iteration limit");

   // A new result shows up only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid without finishing an item");

endmodule

// ===== rtl/burning_ship_escape_time_unit.sv =====
// ----------------------------------------------------------------------------
// burning_ship_escape_time_unit
// Burning Ship escape-time engine: pixel index in, iteration count and inside
// flag out, one pixel at a time.
// ----------------------------------------------------------------------------
// The COORD and SETUP states form the point c after a pixel is accepted,
// and each map step then passes through the square/product multipliers
// (MUL) and the fold and escape-test stage (ADD); at most the iteration
// limit of map steps are run. A pixel ends in MUL when its count reaches
// the limit, or in ADD after the closing squares when its escape test
// fires, and the FINISH state then moves the result into the output
// register. A new pixel is taken as soon as the previous one has reached
// the output register, even while that result is still waiting to be
// taken; the new pixel then holds in FINISH until the waiting result is
// taken.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: column [11:0], row [23:12]
   input  logic [bse_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: escape_count [15:0]
   output logic [bse_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: inside_res [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [bse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bse_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bse_pkg::*;

   bse_cmd_type    cmd;
   bse_status_type status;

   // Sequencer
   bse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and configuration
   bse_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .column       (req_tdata[COLUMN_BITS-1:0]),
      .row          (req_tdata[COLUMN_BITS+ROW_BITS-1:COLUMN_BITS]),
      .cmd          (cmd),
      .status       (status),
      .escape_count (rsp_tdata),
      .inside_res   (rsp_tuser)
   );

endmodule
